FILE: src/selective_pixel_desaturation_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the selective pixel desaturation block
// Property wrappers that vanish when the block is synthesised.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_PIXEL_DESATURATION_ASSERT_SVH
`define SELECTIVE_PIXEL_DESATURATION_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define SPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: src/spd_pkg.sv
// ----------------------------------------------------------------------------
// Selective pixel desaturation package
// Widths, codes, word types and helper functions shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spd_pkg;

    localparam int CH_W      = 8;
    localparam int KEY_W     = 9;
    localparam int HNUM_W    = 14;
    localparam int HQ_W      = 6;
    localparam int PULL_W    = 7;
    localparam int PROD_W    = 15;
    localparam int NUM_W     = 24;
    localparam int DEN_W     = 16;
    localparam int Q_W       = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 3;
    localparam int SAT_W     = 7;
    localparam int PMODE_W   = 2;

    // Key source
    localparam logic [MODE_W-1:0] KEY_LIGHT = 3'd0;
    localparam logic [MODE_W-1:0] KEY_HUE   = 3'd1;
    localparam logic [MODE_W-1:0] KEY_RED   = 3'd2;
    localparam logic [MODE_W-1:0] KEY_GREEN = 3'd3;
    localparam logic [MODE_W-1:0] KEY_BLUE  = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUR_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_KEPT   = 2'd3;

    // Pull applied to a pixel
    localparam logic [PMODE_W-1:0] PULL_NONE = 2'd0;
    localparam logic [PMODE_W-1:0] PULL_FULL = 2'd1;
    localparam logic [PMODE_W-1:0] PULL_BAND = 2'd2;

    localparam logic [KEY_W-1:0]  HUE_SECTOR = 9'd60;
    localparam logic [PULL_W-1:0] PERCENT    = 7'd100;

    // Pipeline stage positions
    localparam int STAGES = 12;
    localparam int ST_IN  = 0;
    localparam int ST_H1  = 1;
    localparam int ST_H3  = 3;
    localparam int ST_KEY = 4;
    localparam int ST_MUL = 5;
    localparam int ST_NUM = 6;
    localparam int ST_D1  = 7;
    localparam int ST_D4  = 10;
    localparam int ST_OUT = 11;

    typedef logic [CH_W-1:0] chan_t;

    typedef struct packed {
        chan_t red_in;
        chan_t green_in;
        chan_t blue_in;
    } pixel_in_t;

    typedef struct packed {
        chan_t red_out;
        chan_t green_out;
        chan_t blue_out;
    } pixel_out_t;

    // Everything a pixel carries down the pipe; later fields fill as it goes
    typedef struct packed {
        chan_t [2:0]                ch;     // 0 red, 1 green, 2 blue
        chan_t                      hi;
        chan_t                      lo;
        logic [KEY_W-1:0]           base;
        logic [HNUM_W-1:0]          hrem;
        chan_t                      hden;
        logic [HQ_W-1:0]            hq;
        logic [PMODE_W-1:0]         pmode;
        logic [KEY_W-1:0]           band;
        logic [DEN_W-1:0]           den;
        logic [2:0][PROD_W-1:0]     prod;
        logic [2:0][NUM_W-1:0]      rem;
        logic [2:0][Q_W-1:0]        q;
    } pipe_t;

    function automatic chan_t max3(input chan_t a, input chan_t b, input chan_t c);
        chan_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic chan_t min3(input chan_t a, input chan_t b, input chan_t c);
        chan_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    // Middle channel, ties resolved in a fixed order
    function automatic chan_t mid3(input chan_t r, input chan_t g, input chan_t b,
                                   input chan_t hi, input chan_t lo);
        chan_t v;
        if (r == lo)
        begin
            v = (g == hi) ? b : g;
        end
        else if (g == lo)
        begin
            v = (r == hi) ? b : r;
        end
        else
        begin
            v = (g == hi) ? r : g;
        end
        return v;
    endfunction

    // Hue sector offset, first matching ordering wins
    function automatic logic [KEY_W-1:0] hue_base(input chan_t r, input chan_t g,
                                                  input chan_t b, input chan_t hi,
                                                  input chan_t lo);
        logic [KEY_W-1:0] base;
        base = '0;
        if (r == hi && b == lo)
        begin
            base = '0;
        end
        else if (g == hi && b == lo)
        begin
            base = HUE_SECTOR;
        end
        else if (g == hi && r == lo)
        begin
            base = KEY_W'(HUE_SECTOR * KEY_W'(2));
        end
        else if (b == hi && r == lo)
        begin
            base = KEY_W'(HUE_SECTOR * KEY_W'(3));
        end
        else if (b == hi && g == lo)
        begin
            base = KEY_W'(HUE_SECTOR * KEY_W'(4));
        end
        else if (r == hi && g == lo)
        begin
            base = KEY_W'(HUE_SECTOR * KEY_W'(5));
        end
        return base;
    endfunction

    // One restoring step of the hue division: {quotient bit, remainder}
    function automatic logic [HNUM_W:0] hue_div_step(input logic [HNUM_W-1:0] rem,
                                                     input chan_t den,
                                                     input int unsigned sh);
        logic [HNUM_W-1:0] sub;
        sub = HNUM_W'({{(HNUM_W-CH_W){1'b0}}, den} << sh);
        if (rem >= sub)
        begin
            return {1'b1, HNUM_W'(rem - sub)};
        end
        return {1'b0, rem};
    endfunction

    // One restoring step of the pull division: {quotient bit, remainder}
    function automatic logic [NUM_W:0] pull_div_step(input logic [NUM_W-1:0] rem,
                                                     input logic [DEN_W-1:0] den,
                                                     input int unsigned sh);
        logic [NUM_W-1:0] sub;
        sub = NUM_W'({{(NUM_W-DEN_W){1'b0}}, den} << sh);
        if (rem >= sub)
        begin
            return {1'b1, NUM_W'(rem - sub)};
        end
        return {1'b0, rem};
    endfunction

endpackage

FILE: src/selective_pixel_desaturation.sv
// ----------------------------------------------------------------------------
// Selective pixel desaturation
// Pulls the channels of pixels whose key lies below a threshold toward the
// pixel maximum, with a soft band beneath the threshold.
//
//   channel   direction   handshake               word
//   in        into block  in_valid / in_stall     in_data  (pixel_in_t)
//   out       from block  out_valid / out_stall   out_data (pixel_out_t)
//   cfg       into block  cfg_en                  cfg_index, cfg_data
//
// Twelve register stages: one word enters per cycle while in_stall is low.
// The hue division takes three stages and the pull division four, two
// quotient bits in each stage; these set the depth of the pipe.
// Reset clears the stage valid bits and the config registers (all zero), not the stage data.
// A stall at the output holds only the full stages behind it; empty stages
// still fill, so words are taken until every stage holds one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "selective_pixel_desaturation_assert.svh"

module selective_pixel_desaturation
    import spd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pixel_in_t            in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pixel_out_t           out_data
);

    logic [MODE_W-1:0] key_mode_reg;
    logic [KEY_W-1:0]  threshold_reg;
    logic [KEY_W-1:0]  blur_width_reg;
    logic [SAT_W-1:0]  saturation_kept_reg;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;
    pipe_t             stage_reg  [STAGES];
    pipe_t             stage_calc [STAGES];
    pipe_t             stage_next [STAGES];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mode_reg        <= '0;
            threshold_reg       <= '0;
            blur_width_reg      <= '0;
            saturation_kept_reg <= '0;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                CFG_KEY_MODE:   key_mode_reg        <= cfg_data[MODE_W-1:0];
                CFG_THRESHOLD:  threshold_reg       <= cfg_data[KEY_W-1:0];
                CFG_BLUR_WIDTH: blur_width_reg      <= cfg_data[KEY_W-1:0];
                CFG_SAT_KEPT:   saturation_kept_reg <= cfg_data[SAT_W-1:0];
                default:        key_mode_reg        <= key_mode_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage advances when empty or when the one ahead does
    // ------------------------------------------------------------------
    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign in_stall = !adv[0];

    // ------------------------------------------------------------------
    // Stage logic
    // ------------------------------------------------------------------
    always_comb
    begin
        chan_t                  mid;
        logic [HNUM_W:0]        hstep;
        logic [NUM_W:0]         nstep;
        logic [KEY_W-1:0]       key;
        logic [KEY_W-1:0]       hue;
        logic                   key_ok;
        logic signed [KEY_W:0]  band_lo;
        logic signed [KEY_W:0]  key_s;
        logic [PULL_W-1:0]      keep;
        logic [PULL_W-1:0]      pull;

        // Input: extremes, hue sector, hue numerator and hue denominator
        stage_calc[ST_IN]        = '0;
        stage_calc[ST_IN].ch[0]  = in_data.red_in;
        stage_calc[ST_IN].ch[1]  = in_data.green_in;
        stage_calc[ST_IN].ch[2]  = in_data.blue_in;
        stage_calc[ST_IN].hi     = max3(in_data.red_in, in_data.green_in, in_data.blue_in);
        stage_calc[ST_IN].lo     = min3(in_data.red_in, in_data.green_in, in_data.blue_in);
        mid = mid3(in_data.red_in, in_data.green_in, in_data.blue_in,
                   stage_calc[ST_IN].hi, stage_calc[ST_IN].lo);
        stage_calc[ST_IN].base   = hue_base(in_data.red_in, in_data.green_in,
                                            in_data.blue_in, stage_calc[ST_IN].hi,
                                            stage_calc[ST_IN].lo);
        stage_calc[ST_IN].hrem   = HNUM_W'(chan_t'(mid - stage_calc[ST_IN].lo))
                                   * HNUM_W'(HUE_SECTOR);
        stage_calc[ST_IN].hden   = stage_calc[ST_IN].hi - stage_calc[ST_IN].lo;

        // Hue division, two quotient bits per stage, MSB first
        for (int j = ST_H1; j <= ST_H3; j++)
        begin
            stage_calc[j] = stage_reg[j-1];
            for (int b = 1; b >= 0; b--)
            begin
                hstep = hue_div_step(stage_calc[j].hrem, stage_calc[j].hden,
                                     2 * (ST_H3 - j) + b);
                stage_calc[j].hq   = {stage_calc[j].hq[HQ_W-2:0], hstep[HNUM_W]};
                stage_calc[j].hrem = hstep[HNUM_W-1:0];
            end
        end

        // Key and classification against the band
        stage_calc[ST_KEY] = stage_reg[ST_KEY-1];
        hue = (stage_reg[ST_KEY-1].hi == stage_reg[ST_KEY-1].lo) ? '0 :
              KEY_W'(stage_reg[ST_KEY-1].base + KEY_W'(stage_reg[ST_KEY-1].hq));
        key_ok = 1'b1;
        case (key_mode_reg)
            KEY_LIGHT: key = KEY_W'((KEY_W'(stage_reg[ST_KEY-1].hi)
                                     + KEY_W'(stage_reg[ST_KEY-1].lo)) >> 1);
            KEY_HUE:   key = hue;
            KEY_RED:   key = KEY_W'(stage_reg[ST_KEY-1].ch[0]);
            KEY_GREEN: key = KEY_W'(stage_reg[ST_KEY-1].ch[1]);
            KEY_BLUE:  key = KEY_W'(stage_reg[ST_KEY-1].ch[2]);
            default:
            begin
                key    = '0;
                key_ok = 1'b0;
            end
        endcase
        band_lo = $signed({1'b0, threshold_reg}) - $signed({1'b0, blur_width_reg});
        key_s   = $signed({1'b0, key});
        stage_calc[ST_KEY].pmode = PULL_NONE;
        stage_calc[ST_KEY].band  = blur_width_reg - (threshold_reg - key);
        if (key_ok && key_s < band_lo)
        begin
            stage_calc[ST_KEY].pmode = PULL_FULL;
        end
        else if (key_ok && key_s > band_lo && key < threshold_reg)
        begin
            stage_calc[ST_KEY].pmode = PULL_BAND;
        end
        // Never a zero divisor: a word outside the band divides by the plain percent
        stage_calc[ST_KEY].den = (stage_calc[ST_KEY].pmode == PULL_BAND) ?
                                 DEN_W'(DEN_W'(blur_width_reg) * DEN_W'(PERCENT)) :
                                 DEN_W'(PERCENT);

        // Distance to the maximum times the pull percentage
        stage_calc[ST_MUL] = stage_reg[ST_MUL-1];
        keep = (saturation_kept_reg > PERCENT) ? PERCENT : saturation_kept_reg;
        pull = PERCENT - keep;
        for (int c = 0; c < 3; c++)
        begin
            stage_calc[ST_MUL].prod[c] =
                PROD_W'(chan_t'(stage_reg[ST_MUL-1].hi - stage_reg[ST_MUL-1].ch[c]))
                * PROD_W'(pull);
        end

        // Dividend: band words weighted by their place in the band, no-pull words zero
        stage_calc[ST_NUM] = stage_reg[ST_NUM-1];
        for (int c = 0; c < 3; c++)
        begin
            stage_calc[ST_NUM].q[c] = '0;
            case (stage_reg[ST_NUM-1].pmode)
                PULL_FULL: stage_calc[ST_NUM].rem[c] = NUM_W'(stage_reg[ST_NUM-1].prod[c]);
                PULL_BAND: stage_calc[ST_NUM].rem[c] =
                               NUM_W'(stage_reg[ST_NUM-1].prod[c])
                               * NUM_W'(stage_reg[ST_NUM-1].band);
                default:   stage_calc[ST_NUM].rem[c] = '0;
            endcase
        end

        // Pull division, two quotient bits per stage, MSB first
        for (int j = ST_D1; j <= ST_D4; j++)
        begin
            stage_calc[j] = stage_reg[j-1];
            for (int c = 0; c < 3; c++)
            begin
                for (int b = 1; b >= 0; b--)
                begin
                    nstep = pull_div_step(stage_calc[j].rem[c], stage_calc[j].den,
                                          2 * (ST_D4 - j) + b);
                    stage_calc[j].q[c]   = {stage_calc[j].q[c][Q_W-2:0], nstep[NUM_W]};
                    stage_calc[j].rem[c] = nstep[NUM_W-1:0];
                end
            end
        end

        // Apply the pull
        stage_calc[ST_OUT] = stage_reg[ST_OUT-1];
        for (int c = 0; c < 3; c++)
        begin
            stage_calc[ST_OUT].ch[c] = stage_reg[ST_OUT-1].ch[c]
                                       + chan_t'(stage_reg[ST_OUT-1].q[c]);
        end

        // Hold a stage whose word cannot move on
        for (int i = 0; i < STAGES; i++)
        begin
            stage_next[i] = adv[i] ? stage_calc[i] : stage_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            stage_reg[i] <= stage_next[i];
        end
    end

    assign out_valid          = valid_reg[ST_OUT];
    assign out_data.red_out   = stage_reg[ST_OUT].ch[0];
    assign out_data.green_out = stage_reg[ST_OUT].ch[1];
    assign out_data.blue_out  = stage_reg[ST_OUT].ch[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SPD_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, &valid_reg, "input stalled with an empty stage")
    `SPD_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid, "stalled output word lost")
    `SPD_ASSERT_NOW(a_hue_range, clk, rst_n, valid_reg[ST_H3] && (stage_reg[ST_H3].hi != stage_reg[ST_H3].lo), stage_reg[ST_H3].hq <= HQ_W'(HUE_SECTOR), "hue fraction above one sector")
    `SPD_ASSERT_NOW(a_pull_range, clk, rst_n, valid_reg[ST_D4], (stage_reg[ST_D4].q[0] <= stage_reg[ST_D4].hi - stage_reg[ST_D4].ch[0]) && (stage_reg[ST_D4].q[1] <= stage_reg[ST_D4].hi - stage_reg[ST_D4].ch[1]) && (stage_reg[ST_D4].q[2] <= stage_reg[ST_D4].hi - stage_reg[ST_D4].ch[2]), "pull overshoots the maximum")

endmodule
